// ===== hdl/tgql_pkg.sv =====
// ----------------------------------------------------------------------------
// tgql_pkg: shared types and constants for the glyph quad layout block
// Input and output words, the glyph table entry and the remainder unit
// status, plus the control character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tgql_pkg;

    // parameter defaults
    localparam int GLYPH_SLOTS_DEF = 256;
    localparam int TAB_SPACES_DEF  = 8;
    localparam int COORD_BITS_DEF  = 16;
    localparam int DIVIDEND_W_DEF  = 18;
    localparam int DIVISOR_W_DEF   = 11;

    // operation codes of an input word
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PLACE = 1'b1;

    // control characters
    localparam logic [7:0] CODE_TAB     = 8'd9;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    // configuration register indexes
    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    typedef struct packed {
        logic              func;
        logic [7:0]        code;
        logic              start_of_text;
        logic [7:0]        glyph_width;
        logic [7:0]        glyph_height;
        logic signed [7:0] glyph_descent;
        logic [7:0]        glyph_advance;
        logic [15:0]       tex_left;
        logic [15:0]       tex_right;
        logic [15:0]       tex_top;
        logic [15:0]       tex_bottom;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic [15:0]        vert_u;
        logic [15:0]        vert_v;
        logic [15:0]        vert_index;
        logic               last;
    } t_out_word;

    // one glyph table entry: metrics and texture rectangle
    typedef struct packed {
        logic [7:0]  glyph_width;
        logic [7:0]  glyph_height;
        logic [7:0]  glyph_descent;
        logic [7:0]  glyph_advance;
        logic [15:0] tex_left;
        logic [15:0] tex_right;
        logic [15:0] tex_top;
        logic [15:0] tex_bottom;
    } t_glyph_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

`default_nettype wire

// ===== hdl/tgql_glyph_mem.sv =====
// ----------------------------------------------------------------------------
// tgql_glyph_mem: glyph table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tgql_glyph_mem #(
    parameter int GLYPH_SLOTS = tgql_pkg::GLYPH_SLOTS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire [$clog2(GLYPH_SLOTS)-1:0]   i_waddr,
    input  tgql_pkg::t_glyph_entry          i_wdata,
    input  wire                             i_re,
    input  wire [$clog2(GLYPH_SLOTS)-1:0]   i_raddr,
    output tgql_pkg::t_glyph_entry          o_rdata
);

    tgql_pkg::t_glyph_entry r_mem [GLYPH_SLOTS];
    tgql_pkg::t_glyph_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/tgql_rem_unit.sv =====
// ----------------------------------------------------------------------------
// tgql_rem_unit: bit-serial remainder
// Restoring division of an unsigned dividend by an unsigned divisor, one
// dividend bit a cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module tgql_rem_unit #(
    parameter int DIVIDEND_W = tgql_pkg::DIVIDEND_W_DEF,
    parameter int DIVISOR_W  = tgql_pkg::DIVISOR_W_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire [DIVIDEND_W-1:0]    i_dividend,
    input  wire [DIVISOR_W-1:0]     i_divisor,
    output tgql_pkg::t_rem_stat     o_stat,
    output logic [DIVISOR_W-1:0]    o_rem
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0]  r_dvd, n_dvd;
    logic [DIVISOR_W-1:0]   r_dsr, n_dsr;
    logic [DIVISOR_W-1:0]   r_rem, n_rem;
    logic [DIVISOR_W:0]     trial;
    logic [DIVISOR_W:0]     trial_sub;

    // one restoring step
    assign trial     = {r_rem, r_dvd[DIVIDEND_W-1]};
    assign trial_sub = trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W);
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DIVIDEND_W-2:0], 1'b0};
            n_rem = (trial >= {1'b0, r_dsr}) ? DIVISOR_W'(trial_sub) : DIVISOR_W'(trial);
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

`default_nettype wire

// ===== hdl/text_glyph_quad_layout.sv =====
// Timing: a load is written to the glyph table as it is accepted. A glyph passes the
// registered table read (READ state) and the EMIT state to the output register, then
// gives one vertex a cycle while the output is not stalled. Space and newline pass the
// READ state only; a tab with nonzero spacing then waits in DIV for the bit-serial remainder unit.
// Reset (synchronous, active low) clears pen, origin, line height, vertex count and
// output valid; the glyph table is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// text_glyph_quad_layout: bitmap font text layout, glyph quad generator
// Loads a glyph table and turns placed characters into six textured
// vertices each, moving a pen for tab, newline and space.
// ----------------------------------------------------------------------------
`default_nettype none

module text_glyph_quad_layout #(
    parameter int GLYPH_SLOTS = tgql_pkg::GLYPH_SLOTS_DEF,
    parameter int TAB_SPACES  = tgql_pkg::TAB_SPACES_DEF,
    parameter int COORD_BITS  = tgql_pkg::COORD_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_index,
    input  wire [15:0]          i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  tgql_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output tgql_pkg::t_out_word o_out_word
);

    localparam int SLOT_W = $clog2(GLYPH_SLOTS);
    localparam int WIDE_W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
    localparam int SP_W   = $clog2(255 * TAB_SPACES + 1);

    localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -SAT_MAX - WIDE_W'(1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    localparam logic [2:0] VERT_LAST = 3'd5;

    // saturate to the pen range
    function automatic logic signed [COORD_BITS-1:0] f_sat(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = v;
        if (v > SAT_MAX) c = SAT_MAX;
        if (v < SAT_MIN) c = SAT_MIN;
        return COORD_BITS'(c);
    endfunction

    // quad corners: top-left, bottom-right, bottom-left, top-left, top-right, bottom-right
    function automatic logic f_is_right(input logic [2:0] k);
        return k inside {3'd1, 3'd4, 3'd5};
    endfunction

    function automatic logic f_is_top(input logic [2:0] k);
        return k inside {3'd0, 3'd3, 3'd4};
    endfunction

    // registers
    logic [1:0]                     r_state, n_state;
    logic [7:0]                     r_code, n_code;
    logic                           r_zero, n_zero;
    logic signed [COORD_BITS-1:0]   r_pen_x, n_pen_x;
    logic signed [COORD_BITS-1:0]   r_pen_y, n_pen_y;
    logic [15:0]                    r_vcount, n_vcount;
    logic [7:0]                     r_line_h, n_line_h;
    logic signed [15:0]             r_origin_x, n_origin_x;
    logic signed [15:0]             r_origin_y, n_origin_y;
    logic signed [COORD_BITS-1:0]   r_top, n_top;
    logic signed [COORD_BITS-1:0]   r_bot, n_bot;
    logic signed [COORD_BITS-1:0]   r_right, n_right;
    logic [15:0]                    r_tl, n_tl, r_tr, n_tr, r_tt, n_tt, r_tb, n_tb;
    logic [2:0]                     r_k, n_k;
    logic                           r_col_neg, n_col_neg;
    logic [SP_W-1:0]                r_spacing, n_spacing;
    logic                           r_out_valid, n_out_valid;
    tgql_pkg::t_out_word            r_out_word, n_out_word;

    // glyph table and remainder unit hookup
    logic                       mem_we, mem_re;
    logic [SLOT_W-1:0]          mem_waddr, mem_raddr;
    tgql_pkg::t_glyph_entry     mem_wdata, mem_rdata, g;
    logic                       rem_start;
    logic [WIDE_W-1:0]          rem_dividend;
    tgql_pkg::t_rem_stat        rem_stat;
    logic [SP_W-1:0]            rem_value;

    // handshake helpers
    logic in_acc, out_load, slot_ok, is_right, is_top;

    // datapath terms
    logic signed [WIDE_W-1:0] pen_xw, pen_yw, org_xw, org_yw;
    logic signed [WIDE_W-1:0] w_w, w_h, w_d, w_adv, w_lh, w_col, w_sp, w_rem;
    logic [SP_W-1:0]          spacing;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_load = !r_out_valid || !i_out_stall;
    assign slot_ok  = {1'b0, i_in_word.code} < 9'(GLYPH_SLOTS);

    // table write on load, read on place
    assign mem_we    = in_acc && (i_in_word.func == tgql_pkg::FUNC_LOAD) && slot_ok;
    assign mem_waddr = i_in_word.code[SLOT_W-1:0];
    assign mem_wdata = '{glyph_width:   i_in_word.glyph_width,
                         glyph_height:  i_in_word.glyph_height,
                         glyph_descent: i_in_word.glyph_descent,
                         glyph_advance: i_in_word.glyph_advance,
                         tex_left:      i_in_word.tex_left,
                         tex_right:     i_in_word.tex_right,
                         tex_top:       i_in_word.tex_top,
                         tex_bottom:    i_in_word.tex_bottom};
    assign mem_re    = in_acc && (i_in_word.func == tgql_pkg::FUNC_PLACE);
    assign mem_raddr = ((i_in_word.code == tgql_pkg::CODE_TAB) ||
                        (i_in_word.code == tgql_pkg::CODE_SPACE))
                       ? SLOT_W'(tgql_pkg::CODE_SPACE) : i_in_word.code[SLOT_W-1:0];

    tgql_glyph_mem #(
        .GLYPH_SLOTS (GLYPH_SLOTS)
    ) u_glyph_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tgql_rem_unit #(
        .DIVIDEND_W (WIDE_W),
        .DIVISOR_W  (SP_W)
    ) u_rem_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dividend),
        .i_divisor  (spacing),
        .o_stat     (rem_stat),
        .o_rem      (rem_value)
    );

    // out-of-range codes see an all-zero glyph
    assign g = r_zero ? '0 : mem_rdata;

    // widened operands
    assign pen_xw  = WIDE_W'(r_pen_x);
    assign pen_yw  = WIDE_W'(r_pen_y);
    assign org_xw  = WIDE_W'(r_origin_x);
    assign org_yw  = WIDE_W'(r_origin_y);
    assign w_w     = WIDE_W'(g.glyph_width);
    assign w_h     = WIDE_W'(g.glyph_height);
    assign w_d     = {{(WIDE_W-8){g.glyph_descent[7]}}, g.glyph_descent};
    assign w_adv   = WIDE_W'(g.glyph_advance);
    assign w_lh    = WIDE_W'(r_line_h);
    assign w_col   = pen_xw - org_xw;
    assign w_sp    = WIDE_W'(r_spacing);
    assign w_rem   = r_col_neg ? -WIDE_W'(rem_value) : WIDE_W'(rem_value);
    assign spacing = SP_W'(32'(g.glyph_advance) * TAB_SPACES);

    assign rem_dividend = w_col[WIDE_W-1] ? WIDE_W'(-w_col) : WIDE_W'(w_col);

    assign is_right = f_is_right(r_k);
    assign is_top   = f_is_top(r_k);

    // sequencer and pen update
    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_zero      = r_zero;
        n_pen_x     = r_pen_x;
        n_pen_y     = r_pen_y;
        n_vcount    = r_vcount;
        n_line_h    = r_line_h;
        n_origin_x  = r_origin_x;
        n_origin_y  = r_origin_y;
        n_top       = r_top;
        n_bot       = r_bot;
        n_right     = r_right;
        n_tl        = r_tl;
        n_tr        = r_tr;
        n_tt        = r_tt;
        n_tb        = r_tb;
        n_k         = r_k;
        n_col_neg   = r_col_neg;
        n_spacing   = r_spacing;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        rem_start   = 1'b0;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // configuration writes
        if (i_cfg_we) begin
            if (i_cfg_index == tgql_pkg::CFG_ORIGIN_X) begin
                n_origin_x = i_cfg_data;
            end else begin
                n_origin_y = i_cfg_data;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.func == tgql_pkg::FUNC_LOAD) begin
                        if (slot_ok && (i_in_word.glyph_height > r_line_h)) begin
                            n_line_h = i_in_word.glyph_height;
                        end
                    end else begin
                        n_code  = i_in_word.code;
                        n_zero  = !slot_ok;
                        n_state = ST_READ;
                        if (i_in_word.start_of_text) begin
                            n_pen_x  = f_sat(org_xw);
                            n_pen_y  = f_sat(org_yw);
                            n_vcount = '0;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
                case (r_code)
                    tgql_pkg::CODE_TAB: begin
                        n_spacing = spacing;
                        n_col_neg = w_col[WIDE_W-1];
                        if (spacing != '0) begin
                            rem_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                    end
                    tgql_pkg::CODE_NEWLINE: begin
                        n_pen_y = f_sat(pen_yw - w_lh);
                        n_pen_x = f_sat(org_xw);
                    end
                    tgql_pkg::CODE_SPACE: begin
                        n_pen_x = f_sat(pen_xw + w_adv);
                    end
                    default: begin
                        n_top   = f_sat(pen_yw - w_d);
                        n_bot   = f_sat(pen_yw - w_h - w_d);
                        n_right = f_sat(pen_xw + w_w);
                        n_tl    = g.tex_left;
                        n_tr    = g.tex_right;
                        n_tt    = g.tex_top;
                        n_tb    = g.tex_bottom;
                        n_k     = '0;
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_out_valid           = 1'b1;
                    n_out_word.vert_x     = 16'(is_right ? r_right : r_pen_x);
                    n_out_word.vert_y     = 16'(is_top ? r_top : r_bot);
                    n_out_word.vert_u     = is_right ? r_tr : r_tl;
                    n_out_word.vert_v     = is_top ? r_tt : r_tb;
                    n_out_word.vert_index = r_vcount;
                    n_out_word.last       = (r_k == VERT_LAST);
                    n_vcount              = r_vcount + 16'd1;
                    if (r_k == VERT_LAST) begin
                        n_k     = '0;
                        n_pen_x = r_right;
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            ST_DIV: begin
                if (rem_stat.done) begin
                    n_pen_x = f_sat(pen_xw + w_sp - w_rem);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_vcount    <= '0;
            r_line_h    <= '0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pen_x     <= n_pen_x;
            r_pen_y     <= n_pen_y;
            r_vcount    <= n_vcount;
            r_line_h    <= n_line_h;
            r_origin_x  <= n_origin_x;
            r_origin_y  <= n_origin_y;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_zero     <= n_zero;
        r_top      <= n_top;
        r_bot      <= n_bot;
        r_right    <= n_right;
        r_tl       <= n_tl;
        r_tr       <= n_tr;
        r_tt       <= n_tt;
        r_tb       <= n_tb;
        r_col_neg  <= n_col_neg;
        r_spacing  <= n_spacing;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // the remainder unit only runs for a tab in progress
    a_rem_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.busy |-> (r_state == ST_DIV))
        else $error("remainder unit busy outside tab step");

    // a quad that has not shown its last vertex is still being emitted
    a_quad_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.last) |-> (r_state == ST_EMIT))
        else $error("quad left unfinished");

    // vertices of one quad follow back to back with consecutive indexes
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_word.last) |=>
        (o_out_valid &&
         (o_out_word.vert_index == 16'($past(o_out_word.vert_index) + 16'd1))))
        else $error("vertex index not consecutive");

endmodule

`default_nettype wire
